/* rtl/core/i2c_seq_pkg.sv */
// ----------------------------------------------------------------------------
// I2C sequencer package
// Shared types, status codes and defaults for the register transaction
// sequencer.
// ----------------------------------------------------------------------------
package i2c_seq_pkg;

   localparam int BURST_LEN_DEF   = 6;
   localparam int QUEUE_DEPTH_DEF = 4;

   // Status codes reported by the byte-level controller.
   localparam logic [7:0] ST_START    = 8'h08;
   localparam logic [7:0] ST_ADDRW    = 8'h18;
   localparam logic [7:0] ST_TX_ACK   = 8'h28;
   localparam logic [7:0] ST_RESTART  = 8'h10;
   localparam logic [7:0] ST_ADDRR    = 8'h40;
   localparam logic [7:0] ST_RX_ACK   = 8'h50;
   localparam logic [7:0] ST_RX_NACK  = 8'h58;

   typedef enum logic [1:0] {
      FUNC_WRITE  = 2'd0,
      FUNC_READ   = 2'd1,
      FUNC_BURST  = 2'd2,
      FUNC_STATUS = 2'd3
   } func_type;

   typedef enum logic [3:0] {
      PH_IDLE     = 4'd0,
      PH_START    = 4'd1,
      PH_ADDRW    = 4'd2,
      PH_REG      = 4'd3,
      PH_DATA     = 4'd4,
      PH_RESTART  = 4'd5,
      PH_ADDRR    = 4'd6,
      PH_ACKBYTE  = 4'd7,
      PH_LASTBYTE = 4'd8
   } phase_type;

   typedef enum logic [2:0] {
      ACT_NONE   = 3'd0,
      ACT_START  = 3'd1,
      ACT_TX     = 3'd2,
      ACT_RXACK  = 3'd3,
      ACT_RXNACK = 3'd4,
      ACT_STOP   = 3'd5
   } action_type;

   typedef enum logic [3:0] {
      ERR_OK       = 4'd0,
      ERR_START    = 4'd1,
      ERR_ADDRW    = 4'd2,
      ERR_REG      = 4'd3,
      ERR_DATA     = 4'd4,
      ERR_RESTART  = 4'd5,
      ERR_ADDRR    = 4'd6,
      ERR_RECEIVE  = 4'd7,
      ERR_BUSY     = 4'd8
   } error_type;

   // Status compare results, worked out in the front end.
   typedef struct packed {
      logic start;
      logic addrw;
      logic tx_ack;
      logic restart;
      logic addrr;
      logic rx_ack;
      logic rx_nack;
   } match_type;

   typedef struct packed {
      func_type   func;
      logic [7:0] device;
      logic [7:0] regaddr;
      logic [7:0] data;
      logic [7:0] rx;
      match_type  match;
   } item_type;

   typedef struct packed {
      action_type action;
      logic [7:0] tx_byte;
      logic       done_res;
      error_type  error_code;
      logic       read_valid;
      logic [7:0] read_data;
      logic [2:0] read_index;
      logic       last;
   } rsp_type;

endpackage

/* rtl/core/i2c_seq_front.sv */
// ----------------------------------------------------------------------------
// I2C sequencer front end
// Accepts transactions, compares the status byte against every expected
// code and holds the classified item until the queue takes it.
// ----------------------------------------------------------------------------
module i2c_seq_front
   import i2c_seq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [1:0] req_func,
   input  logic [7:0] req_device_addr,
   input  logic [7:0] req_reg_addr,
   input  logic [7:0] req_write_data,
   input  logic [7:0] req_bus_status,
   input  logic [7:0] req_rx_byte,
   output logic       item_valid,
   output item_type   item,
   input  logic       item_ready
);

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     take, advance;

   assign advance  = valid_ff && item_ready;
   assign req_full = valid_ff && !item_ready;
   assign take     = req_push && !req_full;

   always_comb begin
      item_in               = item_ff;
      valid_in              = valid_ff && !advance;
      if (take) begin
         valid_in              = 1'b1;
         item_in.func          = func_type'(req_func);
         item_in.device        = req_device_addr;
         item_in.regaddr       = req_reg_addr;
         item_in.data          = req_write_data;
         item_in.rx            = req_rx_byte;
         item_in.match.start   = (req_bus_status == ST_START);
         item_in.match.addrw   = (req_bus_status == ST_ADDRW);
         item_in.match.tx_ack  = (req_bus_status == ST_TX_ACK);
         item_in.match.restart = (req_bus_status == ST_RESTART);
         item_in.match.addrr   = (req_bus_status == ST_ADDRR);
         item_in.match.rx_ack  = (req_bus_status == ST_RX_ACK);
         item_in.match.rx_nack = (req_bus_status == ST_RX_NACK);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

/* rtl/core/i2c_seq_fifo.sv */
// ----------------------------------------------------------------------------
// I2C sequencer item queue
// Small first-in first-out queue between the front and back ends.
// ----------------------------------------------------------------------------
module i2c_seq_fifo
   import i2c_seq_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
   input  logic     clock,
   input  logic     reset,
   input  logic     wr_en,
   input  item_type wr_item,
   output logic     full,
   input  logic     rd_en,
   output item_type rd_item,
   output logic     empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   item_type       mem_ff [DEPTH];
   logic [PW-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]  count_ff, count_in;
   logic           do_wr, do_rd;

   assign full  = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);
   assign do_wr = wr_en && !full;
   assign do_rd = rd_en && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_item;
      end
   end

   assign rd_item = mem_ff[rd_ptr_ff];

endmodule

/* rtl/core/i2c_seq_back.sv */
// ----------------------------------------------------------------------------
// I2C sequencer back end
// Runs the transaction state machine, one queued item per cycle while the
// output register is free or popped, and holds the result until it is popped.
// ----------------------------------------------------------------------------
module i2c_seq_back
   import i2c_seq_pkg::*;
#(
   parameter int BURST_LEN = BURST_LEN_DEF
)
(
   input  logic     clock,
   input  logic     reset,
   input  logic     item_valid,
   input  item_type item,
   output logic     item_pop,
   output logic     rsp_empty,
   input  logic     rsp_pop,
   output rsp_type  rsp
);

   // The byte counter must reach BURST_LEN - 1 and supply a 3-bit index.
   localparam int CNT_W = ($clog2(BURST_LEN) > 3) ? $clog2(BURST_LEN) : 3;

   phase_type        phase_ff, phase_in;
   func_type         mode_ff, mode_in;
   logic [7:0]       device_ff, device_in;
   logic [7:0]       register_ff, register_in;
   logic [7:0]       data_ff, data_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             out_valid_ff, out_valid_in;
   rsp_type          rsp_ff, rsp_in;
   logic             step;
   logic             burst_end;
   logic             is_cmd;

   assign step      = item_valid && (!out_valid_ff || rsp_pop);
   assign item_pop  = step;
   assign is_cmd    = (item.func != FUNC_STATUS);
   assign burst_end = (count_ff == CNT_W'(BURST_LEN - 2));

   // Next state.
   always_comb begin
      phase_in    = phase_ff;
      mode_in     = mode_ff;
      device_in   = device_ff;
      register_in = register_ff;
      data_in     = data_ff;
      count_in    = count_ff;
      if (step) begin
         if (is_cmd) begin
            if (phase_ff == PH_IDLE) begin
               mode_in     = item.func;
               device_in   = item.device;
               register_in = item.regaddr;
               data_in     = item.data;
               count_in    = '0;
               phase_in    = PH_START;
            end
         end else begin
            case (phase_ff)
               PH_IDLE: begin
                  phase_in = PH_IDLE;
               end
               PH_START: begin
                  phase_in = item.match.start ? PH_ADDRW : PH_IDLE;
               end
               PH_ADDRW: begin
                  phase_in = item.match.addrw ? PH_REG : PH_IDLE;
               end
               PH_REG: begin
                  if (!item.match.tx_ack) begin
                     phase_in = PH_IDLE;
                  end else if (mode_ff == FUNC_WRITE) begin
                     phase_in = PH_DATA;
                  end else begin
                     phase_in = PH_RESTART;
                  end
               end
               PH_DATA: begin
                  phase_in = PH_IDLE;
               end
               PH_RESTART: begin
                  phase_in = item.match.restart ? PH_ADDRR : PH_IDLE;
               end
               PH_ADDRR: begin
                  if (!item.match.addrr) begin
                     phase_in = PH_IDLE;
                  end else begin
                     count_in = '0;
                     phase_in = (mode_ff == FUNC_BURST) ? PH_ACKBYTE : PH_LASTBYTE;
                  end
               end
               PH_ACKBYTE: begin
                  if (!item.match.rx_ack) begin
                     phase_in = PH_IDLE;
                  end else begin
                     count_in = count_ff + 1'b1;
                     if (burst_end) begin
                        phase_in = PH_LASTBYTE;
                     end
                  end
               end
               PH_LASTBYTE: begin
                  phase_in = PH_IDLE;
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
      end
   end

   // Result of the current item.
   always_comb begin
      rsp_in = '0;
      if (is_cmd) begin
         if (phase_ff == PH_IDLE) begin
            rsp_in.action = ACT_START;
         end else begin
            rsp_in.error_code = ERR_BUSY;
         end
      end else begin
         case (phase_ff)
            PH_IDLE: begin
               rsp_in = '0;
            end
            PH_START: begin
               if (item.match.start) begin
                  rsp_in.action  = ACT_TX;
                  rsp_in.tx_byte = device_ff;
               end else begin
                  rsp_in.action     = ACT_STOP;
                  rsp_in.done_res   = 1'b1;
                  rsp_in.error_code = ERR_START;
               end
            end
            PH_ADDRW: begin
               if (item.match.addrw) begin
                  rsp_in.action  = ACT_TX;
                  rsp_in.tx_byte = register_ff;
               end else begin
                  rsp_in.action     = ACT_STOP;
                  rsp_in.done_res   = 1'b1;
                  rsp_in.error_code = ERR_ADDRW;
               end
            end
            PH_REG: begin
               if (!item.match.tx_ack) begin
                  rsp_in.action     = ACT_STOP;
                  rsp_in.done_res   = 1'b1;
                  rsp_in.error_code = ERR_REG;
               end else if (mode_ff == FUNC_WRITE) begin
                  rsp_in.action  = ACT_TX;
                  rsp_in.tx_byte = data_ff;
               end else begin
                  rsp_in.action = ACT_START;
               end
            end
            PH_DATA: begin
               rsp_in.action   = ACT_STOP;
               rsp_in.done_res = 1'b1;
               if (!item.match.tx_ack) begin
                  rsp_in.error_code = ERR_DATA;
               end
            end
            PH_RESTART: begin
               if (item.match.restart) begin
                  rsp_in.action  = ACT_TX;
                  rsp_in.tx_byte = device_ff ^ 8'h01;
               end else begin
                  rsp_in.action     = ACT_STOP;
                  rsp_in.done_res   = 1'b1;
                  rsp_in.error_code = ERR_RESTART;
               end
            end
            PH_ADDRR: begin
               if (!item.match.addrr) begin
                  rsp_in.action     = ACT_STOP;
                  rsp_in.done_res   = 1'b1;
                  rsp_in.error_code = ERR_ADDRR;
               end else if (mode_ff == FUNC_BURST) begin
                  rsp_in.action = ACT_RXACK;
               end else begin
                  rsp_in.action = ACT_RXNACK;
               end
            end
            PH_ACKBYTE: begin
               if (!item.match.rx_ack) begin
                  rsp_in.action     = ACT_STOP;
                  rsp_in.done_res   = 1'b1;
                  rsp_in.error_code = ERR_RECEIVE;
               end else begin
                  rsp_in.action     = burst_end ? ACT_RXNACK : ACT_RXACK;
                  rsp_in.read_valid = 1'b1;
                  rsp_in.read_data  = item.rx;
                  rsp_in.read_index = count_ff[2:0];
               end
            end
            PH_LASTBYTE: begin
               rsp_in.action   = ACT_STOP;
               rsp_in.done_res = 1'b1;
               if (!item.match.rx_nack) begin
                  rsp_in.error_code = ERR_RECEIVE;
               end else begin
                  rsp_in.read_valid = 1'b1;
                  rsp_in.read_data  = item.rx;
                  rsp_in.read_index = count_ff[2:0];
                  rsp_in.last       = 1'b1;
               end
            end
            default: begin
               rsp_in = '0;
            end
         endcase
      end
   end

   assign out_valid_in = step || (out_valid_ff && !rsp_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         mode_ff      <= FUNC_WRITE;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         mode_ff      <= mode_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
      device_ff   <= device_in;
      register_ff <= register_in;
      data_ff     <= data_in;
      if (step) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp       = rsp_ff;

endmodule

/* rtl/core/i2c_register_transaction_sequencer_top.sv */
// ----------------------------------------------------------------------------
// I2C register transaction sequencer
// Drives a byte-level two-wire bus controller through register write,
// single read and burst read transactions.
// ----------------------------------------------------------------------------
// Every transaction pushed in produces exactly one result transaction. A
// command (write, single read, burst read) starts a bus sequence and yields
// a start action; each following controller status event is checked against
// the code expected for the step in progress and yields the next controller
// action, a received byte where one arrives, or a stop with a numbered error
// on a mismatch. A command that arrives while a sequence is running is
// refused with the busy error and leaves the sequence untouched; a status
// event while idle yields an all-zero result. The block takes one
// transaction per clock cycle while results are popped: the front end
// registers and classifies a transaction (all status compares are done
// there), a short queue holds classified transactions, and the back end
// state machine retires one per cycle into an output register that can be
// refilled in the same cycle it is popped. A result passes through the front
// register, the queue and the output register. The input side reports full
// only when the queue and the front register are both occupied, which
// happens only while results are not being popped.
// ----------------------------------------------------------------------------
module i2c_register_transaction_sequencer_top
   import i2c_seq_pkg::*;
#(
   parameter int BURST_LEN   = BURST_LEN_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [1:0] req_func,
   input  logic [7:0] req_device_addr,
   input  logic [7:0] req_reg_addr,
   input  logic [7:0] req_write_data,
   input  logic [7:0] req_bus_status,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [2:0] rsp_action,
   output logic [7:0] rsp_tx_byte,
   output logic       rsp_done_res,
   output logic [3:0] rsp_error_code,
   output logic       rsp_read_valid,
   output logic [7:0] rsp_read_data,
   output logic [2:0] rsp_read_index,
   output logic       rsp_last
);

   // Classified transaction leaving the front end.
   logic     front_valid;
   item_type front_item;
   logic     queue_full;

   // Head of the queue feeding the back end.
   item_type queue_item;
   logic     queue_empty;
   logic     queue_pop;

   rsp_type  rsp;

   i2c_seq_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_func        (req_func),
      .req_device_addr (req_device_addr),
      .req_reg_addr    (req_reg_addr),
      .req_write_data  (req_write_data),
      .req_bus_status  (req_bus_status),
      .req_rx_byte     (req_rx_byte),
      .item_valid      (front_valid),
      .item            (front_item),
      .item_ready      (!queue_full)
   );

   i2c_seq_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (front_valid),
      .wr_item (front_item),
      .full    (queue_full),
      .rd_en   (queue_pop),
      .rd_item (queue_item),
      .empty   (queue_empty)
   );

   i2c_seq_back #(
      .BURST_LEN (BURST_LEN)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (!queue_empty),
      .item       (queue_item),
      .item_pop   (queue_pop),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp        (rsp)
   );

   // The result register fields map directly onto the result ports.
   assign rsp_action     = rsp.action;
   assign rsp_tx_byte    = rsp.tx_byte;
   assign rsp_done_res   = rsp.done_res;
   assign rsp_error_code = rsp.error_code;
   assign rsp_read_valid = rsp.read_valid;
   assign rsp_read_data  = rsp.read_data;
   assign rsp_read_index = rsp.read_index;
   assign rsp_last       = rsp.last;

endmodule

/* rtl/core/i2c_seq_checker.sv */
// ----------------------------------------------------------------------------
// I2C sequencer checker
// Port-level assertions on the result stream of the sequencer.
// ----------------------------------------------------------------------------
module i2c_seq_checker
   import i2c_seq_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_empty,
   input logic       rsp_pop,
   input logic [2:0] rsp_action,
   input logic       rsp_done_res,
   input logic [3:0] rsp_error_code,
   input logic       rsp_read_valid,
   input logic       rsp_last
);

   // Nothing is waiting on the result side right after reset.
   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("result present after reset");

   // Every finished transaction ends with a stop on the bus.
   a_done_stops: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_done_res) |-> (rsp_action == ACT_STOP))
      else $error("done without stop");

   // A refused command issues no action and ends nothing.
   a_busy_quiet: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_error_code == ERR_BUSY) |->
         (rsp_action == ACT_NONE && !rsp_done_res && !rsp_read_valid))
      else $error("busy result carries an action");

   // The final byte of a read closes the transaction without error.
   a_last_done: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_last) |->
         (rsp_read_valid && rsp_done_res && rsp_error_code == ERR_OK))
      else $error("last byte does not end the transaction");

   // An unpopped result stays on the ports.
   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_action)))
      else $error("result changed while waiting");

endmodule

bind i2c_register_transaction_sequencer_top i2c_seq_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_empty      (rsp_empty),
   .rsp_pop        (rsp_pop),
   .rsp_action     (rsp_action),
   .rsp_done_res   (rsp_done_res),
   .rsp_error_code (rsp_error_code),
   .rsp_read_valid (rsp_read_valid),
   .rsp_last       (rsp_last)
);

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// I2C register transaction sequencer testbench
// Sends write, single read and burst read sequences with matching and
// broken controller status codes, predicts every result in step with the
// stimulus, and checks each popped result field by field.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import i2c_seq_pkg::*;

   localparam int BURST = BURST_LEN_DEF;

   // One transaction as presented on the request ports.
   typedef struct {
      func_type   func;
      logic [7:0] device;
      logic [7:0] regaddr;
      logic [7:0] data;
      logic [7:0] status;
      logic [7:0] rx;
   } bus_cmd_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_push = 1'b0;
   logic       req_full;
   logic [1:0] req_func = FUNC_WRITE;
   logic [7:0] req_device_addr = 8'h00;
   logic [7:0] req_reg_addr = 8'h00;
   logic [7:0] req_write_data = 8'h00;
   logic [7:0] req_bus_status = 8'h00;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_empty;
   logic       rsp_pop = 1'b0;
   logic [2:0] rsp_action;
   logic [7:0] rsp_tx_byte;
   logic       rsp_done_res;
   logic [3:0] rsp_error_code;
   logic       rsp_read_valid;
   logic [7:0] rsp_read_data;
   logic [2:0] rsp_read_index;
   logic       rsp_last;

   // Transactions waiting to be driven, and the results predicted for the
   // transactions that the block has already taken, oldest first.
   bus_cmd_type pending_items[$];
   rsp_type     expected_steps[$];
   int          error_count = 0;

   // Private copy of the sequencer state, advanced once per accepted
   // transaction.
   phase_type   seq_phase = PH_IDLE;
   func_type    seq_mode = FUNC_WRITE;
   logic [7:0]  seq_device = 8'h00;
   logic [7:0]  seq_register = 8'h00;
   logic [7:0]  seq_data = 8'h00;
   int unsigned seq_count = 0;

   i2c_register_transaction_sequencer_top u_top (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_func        (req_func),
      .req_device_addr (req_device_addr),
      .req_reg_addr    (req_reg_addr),
      .req_write_data  (req_write_data),
      .req_bus_status  (req_bus_status),
      .req_rx_byte     (req_rx_byte),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_action      (rsp_action),
      .rsp_tx_byte     (rsp_tx_byte),
      .rsp_done_res    (rsp_done_res),
      .rsp_error_code  (rsp_error_code),
      .rsp_read_valid  (rsp_read_valid),
      .rsp_read_data   (rsp_read_data),
      .rsp_read_index  (rsp_read_index),
      .rsp_last        (rsp_last)
   );

   always #5 clock = ~clock;

   // A status mismatch always ends the sequence with a stop and the error
   // code of the step that was in progress.
   function automatic rsp_type abort_step(input error_type code);
      rsp_type r;
      r = '0;
      r.action = ACT_STOP;
      r.done_res = 1'b1;
      r.error_code = code;
      seq_phase = PH_IDLE;
      return r;
   endfunction

   // Works out the result of one accepted transaction and moves the private
   // sequencer state on.
   function automatic rsp_type next_bus_step(input bus_cmd_type it);
      rsp_type r;
      r = '0;
      if (it.func != FUNC_STATUS) begin
         // A command is refused while a sequence is running; otherwise it
         // latches its operands and asks the controller for a start.
         if (seq_phase != PH_IDLE) begin
            r.error_code = ERR_BUSY;
         end else begin
            seq_mode = it.func;
            seq_device = it.device;
            seq_register = it.regaddr;
            seq_data = it.data;
            seq_count = 0;
            seq_phase = PH_START;
            r.action = ACT_START;
         end
         return r;
      end
      case (seq_phase)
         PH_START: begin
            if (it.status != ST_START) r = abort_step(ERR_START);
            else begin
               r.action = ACT_TX;
               r.tx_byte = seq_device;
               seq_phase = PH_ADDRW;
            end
         end
         PH_ADDRW: begin
            if (it.status != ST_ADDRW) r = abort_step(ERR_ADDRW);
            else begin
               r.action = ACT_TX;
               r.tx_byte = seq_register;
               seq_phase = PH_REG;
            end
         end
         PH_REG: begin
            if (it.status != ST_TX_ACK) r = abort_step(ERR_REG);
            else if (seq_mode == FUNC_WRITE) begin
               r.action = ACT_TX;
               r.tx_byte = seq_data;
               seq_phase = PH_DATA;
            end else begin
               r.action = ACT_START;
               seq_phase = PH_RESTART;
            end
         end
         PH_DATA: begin
            if (it.status != ST_TX_ACK) r = abort_step(ERR_DATA);
            else begin
               r.action = ACT_STOP;
               r.done_res = 1'b1;
               seq_phase = PH_IDLE;
            end
         end
         PH_RESTART: begin
            if (it.status != ST_RESTART) r = abort_step(ERR_RESTART);
            else begin
               r.action = ACT_TX;
               r.tx_byte = seq_device ^ 8'h01;
               seq_phase = PH_ADDRR;
            end
         end
         PH_ADDRR: begin
            if (it.status != ST_ADDRR) r = abort_step(ERR_ADDRR);
            else begin
               seq_count = 0;
               if (seq_mode == FUNC_BURST) begin
                  r.action = ACT_RXACK;
                  seq_phase = PH_ACKBYTE;
               end else begin
                  r.action = ACT_RXNACK;
                  seq_phase = PH_LASTBYTE;
               end
            end
         end
         PH_ACKBYTE: begin
            if (it.status != ST_RX_ACK) r = abort_step(ERR_RECEIVE);
            else begin
               r.read_valid = 1'b1;
               r.read_data = it.rx;
               r.read_index = seq_count[2:0];
               seq_count++;
               if (seq_count >= BURST - 1) begin
                  r.action = ACT_RXNACK;
                  seq_phase = PH_LASTBYTE;
               end else begin
                  r.action = ACT_RXACK;
               end
            end
         end
         PH_LASTBYTE: begin
            // The final byte and the stop travel in the same result.
            if (it.status != ST_RX_NACK) r = abort_step(ERR_RECEIVE);
            else begin
               r.read_valid = 1'b1;
               r.read_data = it.rx;
               r.read_index = seq_count[2:0];
               r.last = 1'b1;
               r.action = ACT_STOP;
               r.done_res = 1'b1;
               seq_phase = PH_IDLE;
            end
         end
         default: seq_phase = PH_IDLE;  // status while idle is ignored
      endcase
      return r;
   endfunction

   function automatic logic [7:0] rand8();
      return 8'($urandom_range(0, 255));
   endfunction

   // Picks a status code that differs from the one the step is waiting for.
   // Half the time it is another legal code, which is the likelier bus fault.
   function automatic logic [7:0] wrong_status(input logic [7:0] good);
      logic [7:0] s;
      do begin
         if ($urandom_range(0, 1) == 0) begin
            case ($urandom_range(0, 6))
               0: s = ST_START;
               1: s = ST_ADDRW;
               2: s = ST_TX_ACK;
               3: s = ST_RESTART;
               4: s = ST_ADDRR;
               5: s = ST_RX_ACK;
               default: s = ST_RX_NACK;
            endcase
         end else begin
            s = rand8();
         end
      end while (s == good);
      return s;
   endfunction

   task automatic add_item(input func_type f, input logic [7:0] dev, input logic [7:0] reg_a,
                           input logic [7:0] wdata, input logic [7:0] status,
                           input logic [7:0] rx);
      bus_cmd_type it;
      it.func = f;
      it.device = dev;
      it.regaddr = reg_a;
      it.data = wdata;
      it.status = status;
      it.rx = rx;
      pending_items.push_back(it);
   endtask

   // Queues one command and the status events of its sequence. The status
   // at index fail_at (if not negative) is replaced by a wrong one and the
   // sequence ends there. With probability busy_pct a stray command is
   // slipped in before each status event. A negative rx_fill gives random
   // received bytes. Fields that the step ignores carry random values.
   task automatic queue_bus_transaction(input func_type kind, input logic [7:0] dev,
                                        input logic [7:0] reg_a, input logic [7:0] wdata,
                                        input int fail_at, input int busy_pct,
                                        input int rx_fill);
      logic [7:0] codes[$];
      logic [7:0] rx;
      codes.push_back(ST_START);
      codes.push_back(ST_ADDRW);
      codes.push_back(ST_TX_ACK);
      if (kind == FUNC_WRITE) begin
         codes.push_back(ST_TX_ACK);
      end else begin
         codes.push_back(ST_RESTART);
         codes.push_back(ST_ADDRR);
         if (kind == FUNC_BURST) begin
            for (int i = 0; i < BURST - 1; i++) codes.push_back(ST_RX_ACK);
         end
         codes.push_back(ST_RX_NACK);
      end
      add_item(kind, dev, reg_a, wdata, rand8(), rand8());
      foreach (codes[i]) begin
         if ($urandom_range(0, 99) < busy_pct) begin
            add_item(func_type'($urandom_range(0, 2)), rand8(), rand8(), rand8(), rand8(),
                     rand8());
         end
         rx = (rx_fill < 0) ? rand8() : rx_fill[7:0];
         if (i == fail_at) begin
            add_item(FUNC_STATUS, rand8(), rand8(), rand8(), wrong_status(codes[i]), rx);
            return;
         end
         add_item(FUNC_STATUS, rand8(), rand8(), rand8(), codes[i], rx);
      end
   endtask

   // Waits until every queued transaction has been taken and every predicted
   // result has been popped, or until the cycle budget runs out.
   task automatic wait_for_idle(input int max_cycles);
      int waited;
      waited = 0;
      while ((pending_items.size() != 0 || req_push || expected_steps.size() != 0) &&
             waited < max_cycles) begin
         @(negedge clock);
         waited++;
      end
   endtask

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endfunction

   // Sender. It works in bursts of random length separated by random gaps,
   // and some gaps are empty so that long back-to-back stretches occur. The
   // transaction on the ports is held until the block takes it; the result
   // is predicted at the edge where it is taken.
   bus_cmd_type cur_item;
   int          burst_left = 0;
   int          gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
         burst_left = 0;
         gap_left = 0;
      end else begin
         if (req_push && !req_full) expected_steps.push_back(next_bus_step(cur_item));
         if (req_push && req_full) begin
            // Refused this cycle: keep the same transaction on the ports.
         end else if (gap_left > 0) begin
            gap_left--;
            req_push <= 1'b0;
         end else if (pending_items.size() != 0) begin
            cur_item = pending_items.pop_front();
            req_func <= cur_item.func;
            req_device_addr <= cur_item.device;
            req_reg_addr <= cur_item.regaddr;
            req_write_data <= cur_item.data;
            req_bus_status <= cur_item.status;
            req_rx_byte <= cur_item.rx;
            req_push <= 1'b1;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 32);
               gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
            end
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   // Receiver. It switches at random among four stall styles: never stalling,
   // random half rate, rare pops that let the block back up into its full
   // state, and a strict alternating pattern.
   int stall_style = 0;
   int stall_cycle = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
         stall_style = 0;
         stall_cycle = 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_steps.size() == 0) begin
               $error("result transaction popped with no prediction waiting");
               error_count++;
            end else begin
               rsp_type want;
               want = expected_steps.pop_front();
               check_field("action", 8'(want.action), 8'(rsp_action));
               check_field("tx_byte", want.tx_byte, rsp_tx_byte);
               check_field("done_res", 8'(want.done_res), 8'(rsp_done_res));
               check_field("error_code", 8'(want.error_code), 8'(rsp_error_code));
               check_field("read_valid", 8'(want.read_valid), 8'(rsp_read_valid));
               check_field("read_data", want.read_data, rsp_read_data);
               check_field("read_index", 8'(want.read_index), 8'(rsp_read_index));
               check_field("last", 8'(want.last), 8'(rsp_last));
            end
         end
         stall_cycle++;
         if (stall_cycle % 64 == 0) stall_style = $urandom_range(0, 3);
         case (stall_style)
            0: rsp_pop <= 1'b1;
            1: rsp_pop <= ($urandom_range(0, 1) == 1);
            2: rsp_pop <= ($urandom_range(0, 5) == 0);
            default: rsp_pop <= stall_cycle[0];
         endcase
      end
   end

   // Stimulus. The directed part walks through each command type, the
   // ignored status event, a refused command, a start mismatch and a data
   // mismatch, with the field extremes. The random part is mostly complete
   // sequences with random content, plus broken sequences, stray commands
   // and idle status noise. The sender drains completely between parts,
   // which also holds off new transactions until every result is back.
   initial begin
      int       useful;
      int       n0;
      int       pick;
      int       steps;
      int       fail_at;
      func_type kind;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Status event with no sequence running.
      add_item(FUNC_STATUS, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF);
      // Clean register write.
      queue_bus_transaction(FUNC_WRITE, 8'hFF, 8'h00, 8'hFF, -1, 0, -1);
      // Single read with a refused command before every status event.
      queue_bus_transaction(FUNC_READ, 8'h00, 8'hFF, 8'h00, -1, 100, 0);
      // Burst read that fails right at the start status.
      queue_bus_transaction(FUNC_BURST, 8'hAA, 8'h55, 8'h00, 0, 0, -1);
      // Write whose data byte is not acknowledged.
      queue_bus_transaction(FUNC_WRITE, 8'h55, 8'hAA, 8'h00, 3, 0, 255);
      wait_for_idle(20000);

      for (int seg = 0; seg < 3; seg++) begin
         useful = 0;
         while (useful < 450) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
               add_item(FUNC_STATUS, rand8(), rand8(), rand8(), rand8(), rand8());
            end else begin
               n0 = pending_items.size();
               kind = func_type'($urandom_range(0, 2));
               case (kind)
                  FUNC_WRITE: steps = 4;
                  FUNC_READ:  steps = 6;
                  default:    steps = 5 + BURST;
               endcase
               fail_at = ($urandom_range(0, 99) < 20) ? $urandom_range(0, steps - 1) : -1;
               queue_bus_transaction(kind, rand8(), rand8(), rand8(), fail_at,
                                     ($urandom_range(0, 3) == 0) ? 15 : 0, -1);
               useful += pending_items.size() - n0;
            end
         end
         wait_for_idle(200000);
      end

      // Let the pipeline run on to show any result that should not
      // exist, then report.
      repeat (20) @(negedge clock);
      if (expected_steps.size() != 0) begin
         $error("%0d predicted results never arrived", expected_steps.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("i2c_register_transaction_sequencer_top regression: pass");
      end else begin
         $display("i2c_register_transaction_sequencer_top regression: fail");
      end
      $finish;
   end

   // Watchdog for a block that stops accepting or stops producing.
   initial begin
      #5_000_000;
      $display("i2c_register_transaction_sequencer_top regression: fail");
      $finish;
   end

endmodule
